[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define PDM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define PDM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/pdm_pkg.sv]
package pdm_pkg;

  localparam int unsigned ACT_W  = 8;
  localparam int unsigned WGT_W  = 64;
  localparam int unsigned PAIR_W = 16;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned OPND_W = 24;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned LANE_W = 2;

  // Per-lane controls driven by the top level.
  typedef struct packed {
    logic load;   // capture a new product
    logic acc;    // fold the held product into the sums
    logic clear;  // the held product closes a dot product
  } pdm_ctrl_t;

endpackage

[rtl/packed_int8_dual_mac_array.sv]
// Packed int8 dual multiply-accumulate array.
// Input channel: in_valid_i / in_stall_o carry one activation, a word of LANES
// 16-bit weight pairs and a last flag. Each lane multiplies the activation by
// its packed pair once and accumulates both products into two 32-bit sums.
// Output channel: out_valid_o / out_stall_i carry one item per lane, lane 0
// first, after a last item; final_res_o marks the item of lane LANES-1.
// Lane 0 of a closing item is offered once the item has left the multiply
// stage and its sums are snapped into the output buffer; the other lanes follow
// one per cycle while out_stall_i is low. Throughput: one input item per cycle
// while in_stall_o is low. The output buffer holds one set of LANES sums, so a
// closing item waits in the multiply stage until the last lane of the buffer's
// previous set leaves. The output payload is held unchanged while out_stall_i
// is high, and new input items keep accumulating meanwhile until a closing item
// meets the full buffer. Reset clears all sums to zero and empties the output
// buffer.
module packed_int8_dual_mac_array #(
  parameter int unsigned LANES = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pdm_pkg::ACT_W-1:0]       activation_i,
  input  logic        [pdm_pkg::WGT_W-1:0]       weights_i,
  input  logic                                   last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [pdm_pkg::LANE_W-1:0]      lane_o,
  output logic signed [pdm_pkg::SUM_W-1:0]       sum_low_o,
  output logic signed [pdm_pkg::SUM_W-1:0]       sum_high_o,
  output logic                                   final_res_o
);

  logic                                 s1_valid_d, s1_valid_q;
  logic                                 s1_last_q;
  logic                                 free, blocked, in_accept, advance;
  pdm_pkg::pdm_ctrl_t                   ctrl;
  logic [LANES-1:0][pdm_pkg::SUM_W-1:0] new_low, new_high;

  assign blocked    = s1_valid_q && s1_last_q && !free;
  assign in_stall_o = blocked;
  assign in_accept  = in_valid_i && !blocked;
  assign advance    = s1_valid_q && !blocked;

  assign ctrl.load  = in_accept;
  assign ctrl.acc   = advance;
  assign ctrl.clear = s1_last_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_accept) begin
        s1_last_q <= last_i;
      end
    end
  end

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    pdm_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .act_i      (activation_i),
      .pair_i     (weights_i[n*pdm_pkg::PAIR_W +: pdm_pkg::PAIR_W]),
      .sum_low_o  (new_low[n]),
      .sum_high_o (new_high[n])
    );
  end

  pdm_drain #(
    .LANES (LANES)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (advance && s1_last_q),
    .low_i       (new_low),
    .high_i      (new_high),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lane_o      (lane_o),
    .sum_low_o   (sum_low_o),
    .sum_high_o  (sum_high_o),
    .final_res_o (final_res_o)
  );

endmodule

[rtl/pdm_lane.sv]
module pdm_lane (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pdm_pkg::pdm_ctrl_t                     ctrl_i,
  input  logic signed [pdm_pkg::ACT_W-1:0]       act_i,
  input  logic        [pdm_pkg::PAIR_W-1:0]      pair_i,
  output logic signed [pdm_pkg::SUM_W-1:0]       sum_low_o,
  output logic signed [pdm_pkg::SUM_W-1:0]       sum_high_o
);

  logic signed [pdm_pkg::OPND_W-1:0] opnd;
  logic signed [pdm_pkg::PROD_W-1:0] prod_d, prod_q;
  logic        [pdm_pkg::HALF_W-1:0] c0, c1;
  logic signed [pdm_pkg::SUM_W-1:0]  low_d, low_q, high_d, high_q;

  // High weight sits at bit 16, the unsigned low weight in the bottom byte.
  assign opnd   = $signed({pair_i[15:8], 8'h00, pair_i[7:0]});
  assign prod_d = pdm_pkg::PROD_W'(act_i) * pdm_pkg::PROD_W'(opnd);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  // The low product borrowed from the upper half when it was negative.
  assign c0 = prod_q[pdm_pkg::HALF_W-1:0];
  assign c1 = prod_q[pdm_pkg::PROD_W-1:pdm_pkg::HALF_W]
              + pdm_pkg::HALF_W'(c0[pdm_pkg::HALF_W-1]);

  assign low_d  = low_q  + {{(pdm_pkg::SUM_W-pdm_pkg::HALF_W){c0[pdm_pkg::HALF_W-1]}}, c0};
  assign high_d = high_q + {{(pdm_pkg::SUM_W-pdm_pkg::HALF_W){c1[pdm_pkg::HALF_W-1]}}, c1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else if (ctrl_i.acc) begin
      low_q  <= ctrl_i.clear ? '0 : low_d;
      high_q <= ctrl_i.clear ? '0 : high_d;
    end
  end

  assign sum_low_o  = low_d;
  assign sum_high_o = high_d;

endmodule

[rtl/pdm_drain.sv]
module pdm_drain #(
  parameter int unsigned LANES = 4
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         snap_i,
  input  logic [LANES-1:0][pdm_pkg::SUM_W-1:0]         low_i,
  input  logic [LANES-1:0][pdm_pkg::SUM_W-1:0]         high_i,
  output logic                                         free_o,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic [pdm_pkg::LANE_W-1:0]                   lane_o,
  output logic signed [pdm_pkg::SUM_W-1:0]             sum_low_o,
  output logic signed [pdm_pkg::SUM_W-1:0]             sum_high_o,
  output logic                                         final_res_o
);

  localparam int unsigned IdxW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LANES - 1);

  logic [LANES-1:0][pdm_pkg::SUM_W-1:0] low_q, high_q;
  logic                                 busy_q;
  logic [IdxW-1:0]                      idx_q;
  logic                                 advance, at_last;

  assign at_last = (idx_q == LastIdx);
  assign advance = busy_q && !out_stall_i;
  // A new set of sums may land while the final lane of the previous one leaves.
  assign free_o  = !busy_q || (advance && at_last);

  always_ff @(posedge clk_i) begin
    if (snap_i) begin
      low_q  <= low_i;
      high_q <= high_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (snap_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (advance) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o = busy_q;
  assign lane_o      = pdm_pkg::LANE_W'(idx_q);
  assign sum_low_o   = low_q[idx_q];
  assign sum_high_o  = high_q[idx_q];
  assign final_res_o = at_last;

endmodule

[rtl/pdm_checker.sv]
`include "assert_macros.svh"

module pdm_checker #(
  parameter int unsigned LANES = 4
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic        [pdm_pkg::LANE_W-1:0]      lane_o,
  input logic signed [pdm_pkg::SUM_W-1:0]       sum_low_o,
  input logic signed [pdm_pkg::SUM_W-1:0]       sum_high_o,
  input logic                                   final_res_o
);

  localparam logic [pdm_pkg::LANE_W-1:0] LastLane = pdm_pkg::LANE_W'(LANES - 1);

  // A stalled output item stays offered and unchanged.
  `PDM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(lane_o) && $stable(sum_low_o) && $stable(sum_high_o) && $stable(final_res_o))

  // The closing flag sits exactly on the highest lane.
  `PDM_ASSERT_IMP(a_final_lane, out_valid_o, final_res_o == (lane_o == LastLane))

  // Lanes of one dot product leave back to back and in order.
  `PDM_ASSERT_NXT(a_lane_seq, out_valid_o && !out_stall_i && !final_res_o, out_valid_o && (lane_o == $past(lane_o) + 1'b1))

  // A new set of results always starts with lane 0.
  `PDM_ASSERT_NXT(a_lane_start, out_valid_o && !out_stall_i && final_res_o, !out_valid_o || (lane_o == '0))

endmodule

bind packed_int8_dual_mac_array pdm_checker #(.LANES(LANES)) u_pdm_checker (.*);
